FILE: design/ipd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types and constants of the +IPD frame deframer: parser phases,
// marker text, delimiter characters and register map.
// ----------------------------------------------------------------------------
package ipd_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_FIRST   = 2'd1,
    PH_SECOND  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_e;

  // Marker "+IPD," and delimiters
  localparam int unsigned MarkerLen = 5;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  // Register map (word index)
  localparam logic RegKeepLimit = 1'b0;
  localparam logic [15:0] KeepLimitReset = 16'd2047;

  // Character expected at each marker position
  function automatic logic [7:0] marker_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = ChPlus;
      3'd1:    ch = 8'h49;  // I
      3'd2:    ch = 8'h50;  // P
      3'd3:    ch = 8'h44;  // D
      3'd4:    ch = ChComma;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: design/ipd_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_frame_deframer
// Byte-serial deframer for modem "+IPD" data frames.
// ----------------------------------------------------------------------------
// Usage:
//   Received characters enter on rx_byte_i under rx_valid_i / rx_ready_o.
//   The parser hunts for "+IPD,", then reads "<id>,<len>:" or "<len>:" and
//   forwards the next <len> bytes as payload requests on the output channel
//   (out_valid_o / out_ready_i), each tagged with link id, index, announced
//   length, a kept flag (index below keep_limit) and a last flag. Bytes
//   outside a frame give no output.
//   Output: a payload byte appears on the outputs in the cycle after accept.
//   Throughput: one byte per cycle while the output is not stalled; the parse
//   state and the output register are both updated in the accepting cycle, so
//   the next byte is taken in the same cycle in which the previous result leaves.
//   Stall: when the output register is full and out_ready_i is low, rx_ready_o
//   drops and all state holds. Reset: parser returns to hunting, output
//   empty, keep_limit = 2047. keep_limit is written over APB at byte address
//   0; the user must write it only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module ipd_frame_deframer #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Received characters
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  // Payload output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  link_id_o,
  output logic [15:0] byte_index_o,
  output logic [15:0] frame_length_o,
  output logic        kept_o,
  output logic        last_o
);
  import ipd_pkg::*;

  localparam int unsigned CmpW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  // State
  phase_e                 phase_q, phase_d;
  logic [2:0]             mp_q, mp_d;
  logic [COUNT_BITS-1:0]  first_q, first_d;
  logic [COUNT_BITS-1:0]  second_q, second_d;
  logic [7:0]             link_q, link_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic [COUNT_BITS-1:0]  len_q, len_d;
  logic [15:0]            keep_limit_q;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [7:0]  pay_q;
  logic [7:0]  olink_q;
  logic [15:0] oidx_q;
  logic [15:0] olen_q;
  logic        okept_q;
  logic        olast_q;

  logic rx_fire, out_fire, cfg_wr;

  assign out_fire   = out_valid_q && out_ready_i;
  assign rx_ready_o = !out_valid_q || out_ready_i;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  // APB: always ready, single register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegKeepLimit);
  assign prdata = (paddr[2] == RegKeepLimit) ? {16'd0, keep_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_limit_q <= KeepLimitReset;
    end else if (cfg_wr) begin
      keep_limit_q <= pwdata[15:0];
    end
  end

  // Low 16 bits of a count-width value
  function automatic logic [15:0] len_ext(input logic [COUNT_BITS-1:0] v);
    logic [CmpW-1:0] w;
    w = CmpW'(v);
    return w[15:0];
  endfunction

  // Per-byte decode
  logic                  is_digit;
  logic [COUNT_BITS-1:0] digit_val;
  logic [COUNT_BITS-1:0] first_mac, second_mac;
  logic [2:0]            hunt_base;
  logic [2:0]            hunt_next;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [CmpW-1:0]       idx_ext;
  logic                  is_last;

  assign is_digit   = (rx_byte_i >= ChZero) && (rx_byte_i <= ChNine);
  assign digit_val  = COUNT_BITS'(rx_byte_i[3:0]);
  assign first_mac  = (first_q << 3) + (first_q << 1) + digit_val;
  assign second_mac = (second_q << 3) + (second_q << 1) + digit_val;
  assign cnt_inc    = cnt_q + COUNT_BITS'(1);
  assign is_last    = (cnt_inc == len_q);
  assign idx_ext    = CmpW'(cnt_q);

  // Marker matcher: restart from zero outside the hunt phase
  assign hunt_base = (phase_q == PH_HUNT) ? mp_q : 3'd0;
  always_comb begin
    if ((hunt_base < 3'(MarkerLen)) && (rx_byte_i == marker_char(hunt_base))) begin
      hunt_next = hunt_base + 3'd1;
    end else if (rx_byte_i == ChPlus) begin
      hunt_next = 3'd1;
    end else begin
      hunt_next = 3'd0;
    end
  end

  // Next state and result
  logic hunt_sel;
  always_comb begin
    phase_d     = phase_q;
    mp_d        = mp_q;
    first_d     = first_q;
    second_d    = second_q;
    link_d      = link_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    hunt_sel    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    if (rx_fire) begin
      case (phase_q)
        PH_FIRST: begin
          if (is_digit) begin
            first_d = first_mac;
          end else if (rx_byte_i == ChComma) begin
            phase_d = PH_SECOND;
          end else if (rx_byte_i == ChColon) begin
            if (first_q == '0) begin
              phase_d = PH_HUNT;
              mp_d    = 3'd0;
            end else begin
              len_d   = first_q;
              link_d  = 8'd0;
              cnt_d   = '0;
              phase_d = PH_PAYLOAD;
            end
          end else begin
            hunt_sel = 1'b1;
          end
        end
        PH_SECOND: begin
          if (is_digit) begin
            second_d = second_mac;
          end else if (rx_byte_i == ChColon) begin
            if (second_q == '0) begin
              phase_d = PH_HUNT;
              mp_d    = 3'd0;
            end else begin
              len_d   = second_q;
              link_d  = first_q[7:0];
              cnt_d   = '0;
              phase_d = PH_PAYLOAD;
            end
          end else begin
            hunt_sel = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          out_valid_d = 1'b1;
          cnt_d       = cnt_inc;
          if (is_last) begin
            phase_d = PH_HUNT;
            mp_d    = 3'd0;
          end
        end
        default: begin
          hunt_sel = 1'b1;
        end
      endcase

      // Hunt for the marker; a full match opens a header
      if (hunt_sel) begin
        if (hunt_next == 3'(MarkerLen)) begin
          phase_d  = PH_FIRST;
          mp_d     = 3'd0;
          first_d  = '0;
          second_d = '0;
        end else begin
          phase_d = PH_HUNT;
          mp_d    = hunt_next;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      mp_q        <= 3'd0;
      first_q     <= '0;
      second_q    <= '0;
      link_q      <= 8'd0;
      cnt_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      mp_q        <= mp_d;
      first_q     <= first_d;
      second_q    <= second_d;
      link_q      <= link_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result register on a payload byte
  always_ff @(posedge clk_i) begin
    if (rx_fire && (phase_q == PH_PAYLOAD)) begin
      pay_q   <= rx_byte_i;
      olink_q <= link_q;
      oidx_q  <= idx_ext[15:0];
      olen_q  <= len_ext(len_q);
      okept_q <= idx_ext < CmpW'(keep_limit_q);
      olast_q <= is_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = pay_q;
  assign link_id_o      = olink_q;
  assign byte_index_o   = oidx_q;
  assign frame_length_o = olen_q;
  assign kept_o         = okept_q;
  assign last_o         = olast_q;

  // Marker progress only counts while hunting
  a_mp_hunt_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_HUNT) |-> (mp_q == 3'd0))
    else $error("marker progress set outside hunt phase");

  // A frame in progress always has a nonzero length
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (len_q != '0))
    else $error("payload phase with zero length");

  // Every accepted payload byte yields a result
  a_payload_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_fire && (phase_q == PH_PAYLOAD)) |=> out_valid_q)
    else $error("payload byte dropped");

  // Header bytes never create a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !(rx_fire && (phase_q == PH_PAYLOAD))) |=> !out_valid_q)
    else $error("result without payload byte");

  // The last flag marks the final index of the frame
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && olast_q) |-> ((oidx_q + 16'd1) == olen_q))
    else $error("last flag on wrong index");

endmodule
